>>> rtl/virtual_range_finder_raycast_core_defines.svh
// Assertion macros shared by the range finder RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VIRTUAL_RANGE_FINDER_RAYCAST_CORE_DEFINES_SVH
`define VIRTUAL_RANGE_FINDER_RAYCAST_CORE_DEFINES_SVH

// same-cycle implication
`define VRFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VRFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/vrfr_pkg.sv
// Shared constants, types and the sine table for the range finder core.
// No dependencies.
package vrfr_pkg;

  localparam int MAX_WALLS    = 64;
  localparam int WALL_AW      = $clog2(MAX_WALLS);
  localparam int WIDX_W       = 6;
  localparam int WCNT_W       = 7;
  localparam int COORD_BITS   = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 2;
  localparam int ALT_W        = 16;
  localparam int ANG_W        = 16;
  localparam int TRIG_ENTRIES = 1024;
  localparam int TRIG_AW      = $clog2(TRIG_ENTRIES);
  localparam int TRIG_W       = 16;
  localparam int DEN_W        = 2 * TRIG_W;
  localparam int RANGE_W      = 15;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_W        = 16;
  localparam int UPN_W        = 18;
  localparam int DIV_W        = 52;
  localparam int DIV_QB       = 17;
  localparam int DIV_CW       = $clog2(DIV_QB + 1);
  localparam int Q14_SH       = 14;
  localparam int UP_SH        = 28;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [ANG_W-1:0] QUARTER = ANG_W'(16384);
  localparam logic [OUT_W-1:0] NO_HIT  = '1;

  localparam logic [CFG_IDX_W-1:0] REG_CEILING = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WALLS   = CFG_IDX_W'(2);

  localparam logic [RANGE_W-1:0] RST_CEILING = RANGE_W'(2000);
  localparam logic [RANGE_W-1:0] RST_RANGE   = RANGE_W'(4000);
  localparam logic [WCNT_W-1:0]  RST_WALLS   = '0;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic {KIND_LOAD, KIND_QUERY} kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic [WIDX_W-1:0]             wall_index;
    logic signed [COORD_BITS-1:0]  wall_x1;
    logic signed [COORD_BITS-1:0]  wall_y1;
    logic signed [COORD_BITS-1:0]  wall_x2;
    logic signed [COORD_BITS-1:0]  wall_y2;
    logic signed [COORD_BITS-1:0]  pos_east;
    logic signed [COORD_BITS-1:0]  pos_north;
    logic signed [ALT_W-1:0]       altitude;
    logic signed [ANG_W-1:0]       yaw;
    logic signed [ANG_W-1:0]       roll;
    logic signed [ANG_W-1:0]       pitch;
  } item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] ceiling_height;
    logic [RANGE_W-1:0] ray_len;
    logic [WCNT_W-1:0]  wall_count;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DIV_QB-1:0] quo;
  } div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANG, ST_DIR, ST_RD, ST_PREP, ST_MUL, ST_CROSS, ST_RANGE,
    ST_TEST, ST_HDIV, ST_TILT, ST_TDIV, ST_UPM, ST_UPS, ST_UDIV, ST_OUT
  } bk_state_t;

  typedef logic signed [TRIG_W-1:0] sin_tab_t [TRIG_ENTRIES];

  // one series term step: t * x^2 in Q30
  function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
    return (((t * x) >> 30) * x) >> 30;
  endfunction

  // Taylor series sine, rounded to Q14
  function automatic logic signed [TRIG_W-1:0] series_sin(input int unsigned k);
    logic [63:0] p, r, x, term, sum, v;
    logic [1:0]  quad;
    p    = (64'(k) << 32) / 64'(TRIG_ENTRIES);
    quad = p[31:30];
    r    = p & 64'h3FFF_FFFF;
    if (quad[0]) r = 64'h4000_0000 - r;
    x    = (r * TWO_PI_Q30) >> 32;
    term = x;
    sum  = x;
    term = sq_step(term, x) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd20;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd72;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    v    = (sum + 64'd32768) >> 16;
    if (v > 64'd16384) v = 64'd16384;
    return quad[1] ? -TRIG_W'(v) : TRIG_W'(v);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int k = 0; k < TRIG_ENTRIES; k++) t[k] = series_sin(k);
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

>>> rtl/vrfr_div.sv
// Restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on vrfr_pkg.
module vrfr_div import vrfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output div_res_t         res
);

  logic                    busy_r;
  logic [DIV_CW-1:0]       cnt_r;
  logic [DIV_W-1:0]        rem_r;
  logic [DIV_W-1:0]        dsh_r;
  logic [DIV_QB-1:0]       quo_r;
  logic                    ovf_r;
  logic [DIV_W+DIV_QB-1:0] num_ext;
  logic [DIV_W+DIV_QB-1:0] den_top;

  assign num_ext = (DIV_W+DIV_QB)'(num);
  assign den_top = {den, DIV_QB'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CW'(DIV_QB);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= den << (DIV_QB - 1);
      quo_r <= '0;
      ovf_r <= (num_ext >= den_top);
    end else if (busy_r && cnt_r != '0) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[DIV_QB-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[DIV_QB-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign res.done = busy_r && (cnt_r == '0);
  assign res.ovf  = ovf_r;
  assign res.quo  = quo_r;

endmodule

>>> rtl/vrfr_front.sv
// Front end: takes input items, tags load or query, queues them for the back end.
// Depends on vrfr_pkg.
module vrfr_front import vrfr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [WIDX_W-1:0]            in_wall_index,
  input  logic signed [COORD_BITS-1:0] in_wall_x1,
  input  logic signed [COORD_BITS-1:0] in_wall_y1,
  input  logic signed [COORD_BITS-1:0] in_wall_x2,
  input  logic signed [COORD_BITS-1:0] in_wall_y2,
  input  logic signed [COORD_BITS-1:0] in_pos_east,
  input  logic signed [COORD_BITS-1:0] in_pos_north,
  input  logic signed [ALT_W-1:0]      in_altitude,
  input  logic signed [ANG_W-1:0]      in_yaw,
  input  logic signed [ANG_W-1:0]      in_roll,
  input  logic signed [ANG_W-1:0]      in_pitch,
  output logic                         q_valid,
  output item_t                        q_item,
  input  logic                         q_pop
);

  item_t             qmem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  item_t             new_item;

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = qmem_r[rd_ptr_r];

  always_comb begin
    new_item.kind       = in_action ? KIND_QUERY : KIND_LOAD;
    new_item.wall_index = in_wall_index;
    new_item.wall_x1    = in_wall_x1;
    new_item.wall_y1    = in_wall_y1;
    new_item.wall_x2    = in_wall_x2;
    new_item.wall_y2    = in_wall_y2;
    new_item.pos_east   = in_pos_east;
    new_item.pos_north  = in_pos_north;
    new_item.altitude   = in_altitude;
    new_item.yaw        = in_yaw;
    new_item.roll       = in_roll;
    new_item.pitch      = in_pitch;
  end

  always_ff @(posedge clk) begin
    if (push) qmem_r[wr_ptr_r] <= new_item;
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && q_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> rtl/vrfr_back.sv
// Back end: wall table, ray casting sequencer, tilt and ceiling math, result register.
// Depends on vrfr_pkg and vrfr_div.
module vrfr_back import vrfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_left_range,
  output logic [OUT_W-1:0] out_forward_range,
  output logic [OUT_W-1:0] out_right_range,
  output logic [OUT_W-1:0] out_up_range
);

  localparam logic [1:0] RAY_LEFT  = 2'd0;
  localparam logic [1:0] RAY_FWD   = 2'd1;
  localparam logic [1:0] RAY_RIGHT = 2'd2;
  localparam logic [1:0] RAY_UP    = 2'd3;
  localparam logic [1:0] PH_LAST   = 2'd2;

  bk_state_t state_r, state_nxt;
  logic [1:0]  phase_r;
  logic [1:0]  ray_r;
  logic [WALL_AW-1:0] wall_i_r;

  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic signed [ALT_W-1:0]      alt_r;
  logic [ANG_W-1:0]             theta_r, roll_r, pitch_r;
  logic signed [TRIG_W-1:0]     cr_r, cp_r, dx_r, dy_r, trig_q_r;
  logic [ANG_W-1:0]             ray_off, ray_ang, trig_ang;
  logic [TRIG_AW-1:0]           trig_addr;

  logic [4*COORD_BITS-1:0] wall_mem [MAX_WALLS];
  logic [4*COORD_BITS-1:0] rd_data_r;
  logic signed [COORD_BITS-1:0] m_x1, m_y1, m_x2, m_y2;

  logic signed [DIFF_W-1:0]  wx_r, wy_r, qx_r, qy_r;
  logic signed [PROD_W-1:0]  p_dxwy_r, p_dywx_r, p_qxwy_r, p_qywx_r, p_qxdy_r, p_qydx_r;
  logic signed [CROSS_W-1:0] d_c, t_c, u_c, d_r, t_r, u_r;
  logic [DIV_W-1:0]          rd_r, tsh;
  logic                      hit;

  logic               best_v_r;
  logic [RANGE_W-1:0] best_r;
  logic [RANGE_W-1:0] hit_mm;
  logic [WCNT_W-1:0]  n_walls;
  logic               last_wall;
  logic               wall_adv;
  logic signed [TRIG_W-1:0] tilt_c;

  logic signed [DEN_W-1:0] den_r;
  logic [DEN_W-1:0]        ad;
  logic signed [UPN_W-1:0] up_num;
  logic [UPN_W-1:0]        up_an;
  logic                    up_neg_r;
  logic                    up_nz;

  logic             div_start;
  logic [DIV_W-1:0] div_num, div_den;
  div_res_t         div_res;

  logic             res_we;
  logic [OUT_W-1:0] res_val;
  logic [OUT_W-1:0] res_r [4];
  logic             out_load;
  logic             out_valid_r;

  vrfr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  // ---- angle lookup, registered read
  always_comb begin
    case (ray_r)
      RAY_LEFT:  ray_off = QUARTER;
      RAY_RIGHT: ray_off = ANG_W'(0) - QUARTER;
      default:   ray_off = '0;
    endcase
    ray_ang = theta_r + ray_off;
    if (state_r == ST_ANG) trig_ang = ((phase_r == '0) ? roll_r : pitch_r) + QUARTER;
    else trig_ang = (phase_r == '0) ? ray_ang + QUARTER : ray_ang;
    trig_addr = trig_ang[ANG_W-1 -: TRIG_AW];
  end

  always_ff @(posedge clk) begin
    trig_q_r <= SIN_TAB[trig_addr];
  end

  // ---- wall table
  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == KIND_LOAD && 32'(q_item.wall_index) < MAX_WALLS)
      wall_mem[q_item.wall_index[WALL_AW-1:0]] <=
        {q_item.wall_x1, q_item.wall_y1, q_item.wall_x2, q_item.wall_y2};
    rd_data_r <= wall_mem[wall_i_r];
  end

  assign m_x1 = rd_data_r[4*COORD_BITS-1 -: COORD_BITS];
  assign m_y1 = rd_data_r[3*COORD_BITS-1 -: COORD_BITS];
  assign m_x2 = rd_data_r[2*COORD_BITS-1 -: COORD_BITS];
  assign m_y2 = rd_data_r[COORD_BITS-1 -: COORD_BITS];

  // ---- intersection datapath
  assign d_c = CROSS_W'(p_dxwy_r) - CROSS_W'(p_dywx_r);
  assign t_c = CROSS_W'(p_qxwy_r) - CROSS_W'(p_qywx_r);
  assign u_c = CROSS_W'(p_qxdy_r) - CROSS_W'(p_qydx_r);
  assign tsh = DIV_W'($unsigned(t_r)) << Q14_SH;
  assign hit = (d_r != '0) && (t_r > 0) && (u_r > 0) && (u_r < d_r) && (tsh < rd_r);
  assign hit_mm = div_res.quo[RANGE_W-1:0];

  assign n_walls   = (32'(cfg.wall_count) > MAX_WALLS) ? WCNT_W'(MAX_WALLS) : cfg.wall_count;
  assign last_wall = (WCNT_W'(wall_i_r) == n_walls - 1'b1);
  assign tilt_c    = (ray_r == RAY_FWD) ? cp_r : cr_r;

  assign up_num = UPN_W'($signed({1'b0, cfg.ceiling_height})) - UPN_W'(alt_r);
  assign up_an  = up_num[UPN_W-1] ? $unsigned(-up_num) : $unsigned(up_num);
  assign ad     = den_r[DEN_W-1] ? $unsigned(-den_r) : $unsigned(den_r);
  assign up_nz  = div_res.ovf || (div_res.quo != '0);

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_PREP: begin
        wx_r <= DIFF_W'(m_x2) - DIFF_W'(m_x1);
        wy_r <= DIFF_W'(m_y2) - DIFF_W'(m_y1);
        qx_r <= DIFF_W'(m_x1) - DIFF_W'(px_r);
        qy_r <= DIFF_W'(m_y1) - DIFF_W'(py_r);
      end
      ST_MUL: begin
        p_dxwy_r <= dx_r * wy_r;
        p_dywx_r <= dy_r * wx_r;
        p_qxwy_r <= qx_r * wy_r;
        p_qywx_r <= qy_r * wx_r;
        p_qxdy_r <= qx_r * dy_r;
        p_qydx_r <= qy_r * dx_r;
      end
      ST_CROSS: begin
        // orient so the denominator is not negative
        if (d_c < 0) begin
          d_r <= -d_c;
          t_r <= -t_c;
          u_r <= -u_c;
        end else begin
          d_r <= d_c;
          t_r <= t_c;
          u_r <= u_c;
        end
      end
      ST_RANGE: rd_r <= DIV_W'($unsigned(d_r)) * DIV_W'(cfg.ray_len);
      ST_UPM:   den_r <= cp_r * cr_r;
      ST_UPS:   up_neg_r <= (up_num[UPN_W-1] != den_r[DEN_W-1]);
      default: ;
    endcase
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    res_we    = 1'b0;
    res_val   = NO_HIT;
    out_load  = 1'b0;
    wall_adv  = 1'b0;
    unique case (state_r)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        if (q_item.kind == KIND_QUERY) state_nxt = ST_ANG;
      end
      ST_ANG: if (phase_r == PH_LAST) state_nxt = ST_DIR;
      ST_DIR: if (phase_r == PH_LAST) state_nxt = (n_walls != '0) ? ST_RD : ST_TILT;
      ST_RD:    state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CROSS;
      ST_CROSS: state_nxt = ST_RANGE;
      ST_RANGE: state_nxt = ST_TEST;
      ST_TEST: begin
        if (hit) begin
          div_start = 1'b1;
          div_num   = tsh;
          div_den   = DIV_W'($unsigned(d_r));
          state_nxt = ST_HDIV;
        end else begin
          wall_adv  = !last_wall;
          state_nxt = last_wall ? ST_TILT : ST_RD;
        end
      end
      ST_HDIV: if (div_res.done) begin
        wall_adv  = !last_wall;
        state_nxt = last_wall ? ST_TILT : ST_RD;
      end
      ST_TILT: begin
        if (best_v_r && tilt_c > 0) begin
          div_start = 1'b1;
          div_num   = DIV_W'(best_r) << Q14_SH;
          div_den   = DIV_W'($unsigned(tilt_c));
          state_nxt = ST_TDIV;
        end else begin
          res_we    = 1'b1;
          state_nxt = (ray_r == RAY_RIGHT) ? ST_UPM : ST_DIR;
        end
      end
      ST_TDIV: if (div_res.done) begin
        res_we = 1'b1;
        if (!div_res.ovf && div_res.quo[DIV_QB-1:OUT_W] == '0)
          res_val = div_res.quo[OUT_W-1:0];
        state_nxt = (ray_r == RAY_RIGHT) ? ST_UPM : ST_DIR;
      end
      ST_UPM: state_nxt = ST_UPS;
      ST_UPS: begin
        if (den_r == '0) begin
          res_we    = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_W'(up_an) << UP_SH;
          div_den   = DIV_W'(ad);
          state_nxt = ST_UDIV;
        end
      end
      ST_UDIV: if (div_res.done) begin
        res_we = 1'b1;
        if (up_neg_r && up_nz) res_val = '0;
        else if (!div_res.ovf && div_res.quo < DIV_QB'(cfg.ray_len))
          res_val = div_res.quo[OUT_W-1:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_valid_r || !out_stall) begin
        out_load  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- sequencer counters and per-query registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      ray_r    <= '0;
      wall_i_r <= '0;
      best_v_r <= 1'b0;
    end else begin
      phase_r <= (state_nxt != state_r) ? 2'd0 : phase_r + 1'b1;
      if (q_pop) ray_r <= RAY_LEFT;
      else if (res_we) ray_r <= ray_r + 1'b1;
      if (state_r == ST_DIR) begin
        wall_i_r <= '0;
        best_v_r <= 1'b0;
      end else if (wall_adv) begin
        wall_i_r <= wall_i_r + 1'b1;
      end
      if (state_r == ST_HDIV && div_res.done && (!best_v_r || hit_mm < best_r))
        best_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      px_r    <= q_item.pos_east;
      py_r    <= q_item.pos_north;
      alt_r   <= q_item.altitude;
      theta_r <= QUARTER - $unsigned(q_item.yaw);
      roll_r  <= $unsigned(q_item.roll);
      pitch_r <= $unsigned(q_item.pitch);
    end
    if (state_r == ST_ANG && phase_r == 2'd1) cr_r <= trig_q_r;
    if (state_r == ST_ANG && phase_r == PH_LAST) cp_r <= trig_q_r;
    if (state_r == ST_DIR && phase_r == 2'd1) dx_r <= trig_q_r;
    if (state_r == ST_DIR && phase_r == PH_LAST) dy_r <= trig_q_r;
    if (state_r == ST_HDIV && div_res.done && (!best_v_r || hit_mm < best_r)) best_r <= hit_mm;
    if (res_we) res_r[(state_r == ST_UPS || state_r == ST_UDIV) ? RAY_UP : ray_r] <= res_val;
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_range    <= res_r[RAY_LEFT];
      out_forward_range <= res_r[RAY_FWD];
      out_right_range   <= res_r[RAY_RIGHT];
      out_up_range      <= res_r[RAY_UP];
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/virtual_range_finder_raycast_core.sv
// Top level of the virtual range finder: configuration registers, front and back ends.
// Depends on vrfr_pkg, vrfr_front, vrfr_back and the assertion macro header.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-------------------------------------------
//  in_*     | input     | in_valid/in_stall | action, wall index and ends, pose
//  out_*    | output    | out_valid/out_stall | left, forward, right, up ranges
//  cfg_*    | input     | cfg_we           | cfg_index, cfg_data (no read-back)
//
// A load is written to the wall table as it is popped. A query tests each wall in use on
// each of three rays (states ST_RD, ST_PREP, ST_MUL, ST_CROSS, ST_RANGE, ST_TEST), and passes
// through the one shared divider once per wall hit on a ray, once per ray with a hit and a
// positive tilt cosine, and once for the ceiling unless cos(pitch)*cos(roll) is zero.
// Reset (rst_n low, synchronous) empties the queue and result register and loads the
// register defaults; the wall table holds garbage until loaded.
// The two-entry queue takes items until full during a query or while out_stall holds a result.
`include "virtual_range_finder_raycast_core_defines.svh"

module virtual_range_finder_raycast_core import vrfr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [WIDX_W-1:0]            in_wall_index,
  input  logic signed [COORD_BITS-1:0] in_wall_x1,
  input  logic signed [COORD_BITS-1:0] in_wall_y1,
  input  logic signed [COORD_BITS-1:0] in_wall_x2,
  input  logic signed [COORD_BITS-1:0] in_wall_y2,
  input  logic signed [COORD_BITS-1:0] in_pos_east,
  input  logic signed [COORD_BITS-1:0] in_pos_north,
  input  logic signed [ALT_W-1:0]      in_altitude,
  input  logic signed [ANG_W-1:0]      in_yaw,
  input  logic signed [ANG_W-1:0]      in_roll,
  input  logic signed [ANG_W-1:0]      in_pitch,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [OUT_W-1:0]             out_left_range,
  output logic [OUT_W-1:0]             out_forward_range,
  output logic [OUT_W-1:0]             out_right_range,
  output logic [OUT_W-1:0]             out_up_range
);

  cfg_t  cfg_r;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // config registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ceiling_height <= RST_CEILING;
      cfg_r.ray_len        <= RST_RANGE;
      cfg_r.wall_count     <= RST_WALLS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CEILING: cfg_r.ceiling_height <= cfg_data[RANGE_W-1:0];
        REG_RANGE:   cfg_r.ray_len        <= cfg_data[RANGE_W-1:0];
        REG_WALLS:   cfg_r.wall_count     <= cfg_data[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify, two-deep queue
  vrfr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_wall_index (in_wall_index),
    .in_wall_x1    (in_wall_x1),
    .in_wall_y1    (in_wall_y1),
    .in_wall_x2    (in_wall_x2),
    .in_wall_y2    (in_wall_y2),
    .in_pos_east   (in_pos_east),
    .in_pos_north  (in_pos_north),
    .in_altitude   (in_altitude),
    .in_yaw        (in_yaw),
    .in_roll       (in_roll),
    .in_pitch      (in_pitch),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back: wall table, ray sequencer, divider, result register
  vrfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_range    (out_left_range),
    .out_forward_range (out_forward_range),
    .out_right_range   (out_right_range),
    .out_up_range      (out_up_range)
  );

  `VRFR_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "back end popped an empty queue")
  `VRFR_ASSERT_NXT(a_cfg_walls, cfg_we && (cfg_index == REG_WALLS), cfg_r.wall_count == $past(cfg_data[WCNT_W-1:0]), "wall_count write lost")
  `VRFR_ASSERT_NXT(a_cfg_range, cfg_we && (cfg_index == REG_RANGE), cfg_r.ray_len == $past(cfg_data[RANGE_W-1:0]), "ray length write lost")

endmodule
